// ===== hw/rtl/mpcd_pkg.sv =====
package mpcd_pkg;

   localparam int unsigned PeriodCount = 36;
   localparam int unsigned VolumeCount = 65;

   typedef logic [11:0] period_type;
   typedef logic [5:0]  note_type;

   localparam period_type PeriodMin = 12'd113;
   localparam period_type PeriodMax = 12'd856;

   // descending; note n is index n-1
   localparam logic [9:0] PERIOD_TABLE [PeriodCount] = '{
      10'd856, 10'd808, 10'd762, 10'd720, 10'd678, 10'd640,
      10'd604, 10'd570, 10'd538, 10'd508, 10'd480, 10'd453,
      10'd428, 10'd404, 10'd381, 10'd360, 10'd339, 10'd320,
      10'd302, 10'd285, 10'd269, 10'd254, 10'd240, 10'd226,
      10'd214, 10'd202, 10'd190, 10'd180, 10'd170, 10'd160,
      10'd151, 10'd143, 10'd135, 10'd127, 10'd120, 10'd113
   };

   localparam logic [7:0] VOLUME_TABLE [VolumeCount] = '{
      8'd0,
      8'd99,  8'd115, 8'd129, 8'd137, 8'd145, 8'd152, 8'd160, 8'd164,
      8'd168, 8'd172, 8'd176, 8'd180, 8'd183, 8'd187, 8'd191, 8'd193,
      8'd195, 8'd197, 8'd199, 8'd201, 8'd203, 8'd205, 8'd207, 8'd209,
      8'd211, 8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd223, 8'd224,
      8'd225, 8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232,
      8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240,
      8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248,
      8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255, 8'd255
   };

   localparam logic [6:0] VolumeMaxIndex = 7'(VolumeCount - 1);

   typedef enum logic [3:0] {
      CMD_NONE         = 4'd0,
      CMD_ARPEGGIO     = 4'd1,
      CMD_SLIDE_UP     = 4'd2,
      CMD_SLIDE_DOWN   = 4'd3,
      CMD_PORTAMENTO   = 4'd4,
      CMD_SLICE        = 4'd5,
      CMD_CRESC        = 4'd6,
      CMD_DECRESC      = 4'd7,
      CMD_JUMP         = 4'd8,
      CMD_VOLUME       = 4'd9,
      CMD_BREAK        = 4'd10,
      CMD_FINE_CRESC   = 4'd11,
      CMD_FINE_DECRESC = 4'd12,
      CMD_TEMPO        = 4'd13,
      CMD_TICKS        = 4'd14
   } cmd_type;

   // sum of neighbouring periods: twice the midpoint between notes i and i+1
   function automatic logic [12:0] period_pair_sum(input int unsigned idx);
      return 13'(PERIOD_TABLE[idx]) + 13'(PERIOD_TABLE[idx + 1]);
   endfunction

endpackage

// ===== hw/rtl/mpcd_note.sv =====
module mpcd_note
   import mpcd_pkg::*;
(
   input  period_type period,
   output note_type   note
);

   logic [12:0] period_x2;
   logic        in_range;
   note_type    crossed;

   assign period_x2 = {period, 1'b0};
   assign in_range  = (period >= PeriodMin) && (period <= PeriodMax);

   // periods descend, so the nearest index is the number of midpoints above the period;
   // an exact midpoint stays with the lower index
   always_comb begin
      crossed = '0;
      for (int unsigned i = 0; i < PeriodCount - 1; i++) begin
         if (period_x2 < period_pair_sum(i)) begin
            crossed = crossed + note_type'(1);
         end
      end
   end

   assign note = in_range ? (crossed + note_type'(1)) : '0;

endmodule

// ===== hw/rtl/mpcd_effect.sv =====
module mpcd_effect
   import mpcd_pkg::*;
(
   input  logic [3:0] effect_number,
   input  logic [7:0] parameter_byte,
   output cmd_type    command,
   output logic [7:0] data
);

   localparam logic [3:0] EffArpeggio   = 4'h0;
   localparam logic [3:0] EffSlideUp    = 4'h1;
   localparam logic [3:0] EffSlideDown  = 4'h2;
   localparam logic [3:0] EffPortamento = 4'h3;
   localparam logic [3:0] EffSlice      = 4'h9;
   localparam logic [3:0] EffVolSlide   = 4'hA;
   localparam logic [3:0] EffJump       = 4'hB;
   localparam logic [3:0] EffVolume     = 4'hC;
   localparam logic [3:0] EffBreak      = 4'hD;
   localparam logic [3:0] EffExtended   = 4'hE;
   localparam logic [3:0] EffSpeed      = 4'hF;

   localparam logic [3:0] SubFineUp     = 4'hA;
   localparam logic [3:0] SubFineDown   = 4'hB;

   localparam logic [7:0] TempoMax      = 8'h20;

   logic [3:0]  hi;
   logic [3:0]  lo;
   logic [6:0]  vol_index;
   logic [7:0]  break_data;
   logic [10:0] tick_num;
   logic [18:0] tick_prod;
   logic [7:0]  tick_data;

   assign hi = parameter_byte[7:4];
   assign lo = parameter_byte[3:0];

   assign vol_index  = (parameter_byte > 8'(VolumeMaxIndex)) ? VolumeMaxIndex
                                                             : parameter_byte[6:0];
   assign break_data = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};

   // (4d+5)/10 via *205 >> 11, exact over the whole byte range
   assign tick_num  = {1'b0, parameter_byte, 2'b00} + 11'd5;
   assign tick_prod = {8'b0, tick_num} * 19'd205;
   assign tick_data = tick_prod[18:11];

   always_comb begin
      command = CMD_NONE;
      data    = '0;
      case (effect_number)
         EffArpeggio: begin
            if (parameter_byte != 8'd0) begin
               command = CMD_ARPEGGIO;
               data    = parameter_byte;
            end
         end
         EffSlideUp: begin
            command = CMD_SLIDE_UP;
            data    = parameter_byte;
         end
         EffSlideDown: begin
            command = CMD_SLIDE_DOWN;
            data    = parameter_byte;
         end
         EffPortamento: begin
            command = CMD_PORTAMENTO;
            data    = parameter_byte;
         end
         EffSlice: begin
            command = CMD_SLICE;
            data    = parameter_byte;
         end
         EffVolSlide: begin
            if (hi != 4'd0) begin
               command = CMD_CRESC;
               data    = {3'b000, hi, 1'b0};
            end else if (lo != 4'd0) begin
               command = CMD_DECRESC;
               data    = {3'b000, lo, 1'b0};
            end
         end
         EffJump: begin
            command = CMD_JUMP;
            data    = parameter_byte;
         end
         EffVolume: begin
            command = CMD_VOLUME;
            data    = VOLUME_TABLE[vol_index];
         end
         EffBreak: begin
            command = CMD_BREAK;
            data    = break_data;
         end
         EffExtended: begin
            if (hi == SubFineUp) begin
               command = CMD_FINE_CRESC;
               data    = {4'b0000, lo};
            end else if (hi == SubFineDown) begin
               command = CMD_FINE_DECRESC;
               data    = {4'b0000, lo};
            end
         end
         EffSpeed: begin
            if ((parameter_byte >= 8'd1) && (parameter_byte <= TempoMax)) begin
               command = CMD_TEMPO;
               data    = parameter_byte;
            end else begin
               command = CMD_TICKS;
               data    = tick_data;
            end
         end
         default: begin
            command = CMD_NONE;
            data    = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/mod_pattern_cell_decoder_top.sv =====
// Pattern cell decoder: one four-byte cell in, one decoded cell out. busy is
// never raised, so a cell may be started every cycle; each result passes the
// input register and then the result register, and is strobed by rsp_strobe
// for a single cycle. The receiver cannot hold results off and
// must take every transfer as it is strobed. Throughput is one cell per cycle.
module mod_pattern_cell_decoder_top
   import mpcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_first_byte,
   input  logic [7:0] req_second_byte,
   input  logic [7:0] req_third_byte,
   input  logic [7:0] req_fourth_byte,
   output logic       rsp_strobe,
   output logic [5:0] rsp_note,
   output logic [7:0] rsp_instrument,
   output logic [3:0] rsp_effect_command,
   output logic [7:0] rsp_effect_data
);

   logic       cell_valid_ff;
   logic [7:0] byte0_ff;
   logic [7:0] byte1_ff;
   logic [7:0] byte2_ff;
   logic [7:0] byte3_ff;

   logic       rsp_valid_ff;
   note_type   note_ff;
   logic [7:0] instrument_ff;
   cmd_type    command_ff;
   logic [7:0] data_ff;

   note_type   note_in;
   logic [7:0] instrument_in;
   cmd_type    command_in;
   logic [7:0] data_in;
   period_type period;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cell_valid_ff <= start && !busy;
         rsp_valid_ff  <= cell_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         byte0_ff <= req_first_byte;
         byte1_ff <= req_second_byte;
         byte2_ff <= req_third_byte;
         byte3_ff <= req_fourth_byte;
      end
      if (cell_valid_ff) begin
         note_ff       <= note_in;
         instrument_ff <= instrument_in;
         command_ff    <= command_in;
         data_ff       <= data_in;
      end
   end

   assign period        = {byte0_ff[3:0], byte1_ff};
   assign instrument_in = {byte0_ff[7:4], byte2_ff[7:4]};

   mpcd_note u_note (
      .period (period),
      .note   (note_in)
   );

   mpcd_effect u_effect (
      .effect_number  (byte2_ff[3:0]),
      .parameter_byte (byte3_ff),
      .command        (command_in),
      .data           (data_in)
   );

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_note           = note_ff;
   assign rsp_instrument     = instrument_ff;
   assign rsp_effect_command = command_ff;
   assign rsp_effect_data    = data_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted cell gave no result two cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobed with no accepted cell");

   a_note_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_note <= 6'(PeriodCount)))
      else $error("note beyond period table");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_effect_command == CMD_NONE)) |-> (rsp_effect_data == 8'd0))
      else $error("effect data set with no effect");
`endif

endmodule

// ===== sim/mpcd_tb_pkg.sv =====
package mpcd_tb_pkg;

   // effect nibble of cell byte 2
   localparam logic [3:0] EFF_ARPEGGIO   = 4'h0;
   localparam logic [3:0] EFF_SLIDE_UP   = 4'h1;
   localparam logic [3:0] EFF_SLIDE_DOWN = 4'h2;
   localparam logic [3:0] EFF_PORTAMENTO = 4'h3;
   localparam logic [3:0] EFF_VIBRATO    = 4'h4;
   localparam logic [3:0] EFF_TONE_VOL   = 4'h5;
   localparam logic [3:0] EFF_VIB_VOL    = 4'h6;
   localparam logic [3:0] EFF_TREMOLO    = 4'h7;
   localparam logic [3:0] EFF_PAN        = 4'h8;
   localparam logic [3:0] EFF_OFFSET     = 4'h9;
   localparam logic [3:0] EFF_VOL_SLIDE  = 4'hA;
   localparam logic [3:0] EFF_POS_JUMP   = 4'hB;
   localparam logic [3:0] EFF_SET_VOL    = 4'hC;
   localparam logic [3:0] EFF_PAT_BREAK  = 4'hD;
   localparam logic [3:0] EFF_EXTENDED   = 4'hE;
   localparam logic [3:0] EFF_SPEED      = 4'hF;

   // extended sub-commands (parameter high nibble)
   localparam logic [3:0] EXT_FINE_VOL_UP   = 4'hA;
   localparam logic [3:0] EXT_FINE_VOL_DOWN = 4'hB;

endpackage

// ===== sim/mpcd_decode_monitor.sv =====
module mpcd_decode_monitor
   import mpcd_pkg::*;
   import mpcd_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [7:0]  req_first_byte,
   input  logic [7:0]  req_second_byte,
   input  logic [7:0]  req_third_byte,
   input  logic [7:0]  req_fourth_byte,
   input  logic        rsp_strobe,
   input  logic [5:0]  rsp_note,
   input  logic [7:0]  rsp_instrument,
   input  logic [3:0]  rsp_effect_command,
   input  logic [7:0]  rsp_effect_data,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REPORT_LIMIT  = 40;
   localparam int unsigned VOLUME_CEIL   = 64;
   localparam int unsigned TEMPO_MAX     = 32;

   localparam int unsigned CELL_PERIODS [36] = '{
      856, 808, 762, 720, 678, 640, 604, 570, 538, 508, 480, 453,
      428, 404, 381, 360, 339, 320, 302, 285, 269, 254, 240, 226,
      214, 202, 190, 180, 170, 160, 151, 143, 135, 127, 120, 113
   };

   localparam logic [7:0] VOLUME_CURVE [65] = '{
      8'd0,
      8'd99,  8'd115, 8'd129, 8'd137, 8'd145, 8'd152, 8'd160, 8'd164,
      8'd168, 8'd172, 8'd176, 8'd180, 8'd183, 8'd187, 8'd191, 8'd193,
      8'd195, 8'd197, 8'd199, 8'd201, 8'd203, 8'd205, 8'd207, 8'd209,
      8'd211, 8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd223, 8'd224,
      8'd225, 8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232,
      8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240,
      8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248,
      8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255, 8'd255
   };

   typedef struct packed {
      note_type   note;
      logic [7:0] instrument;
      cmd_type    command;
      logic [7:0] data;
   } decoded_cell_type;

   decoded_cell_type expected_cells [$];

   function automatic note_type nearest_note(input logic [11:0] period);
      int unsigned p;
      int unsigned best;
      int unsigned best_gap;
      int unsigned gap;
      p = period;
      if (p == 0 || p > CELL_PERIODS[0] || p < CELL_PERIODS[35]) return '0;
      best = 0;
      best_gap = p - CELL_PERIODS[0] + 2 * (CELL_PERIODS[0] - p);
      for (int unsigned i = 1; i < 36; i++) begin
         gap = (p > CELL_PERIODS[i]) ? p - CELL_PERIODS[i] : CELL_PERIODS[i] - p;
         // strict compare: a tie keeps the lower index
         if (gap < best_gap) begin
            best = i;
            best_gap = gap;
         end
      end
      return note_type'(best + 1);
   endfunction

   function automatic decoded_cell_type decode_cell(input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3);
      decoded_cell_type dec;
      logic [3:0] hi;
      logic [3:0] lo;
      hi = b3[7:4];
      lo = b3[3:0];
      dec.note = nearest_note({b0[3:0], b1});
      dec.instrument = {b0[7:4], b2[7:4]};
      dec.command = CMD_NONE;
      dec.data = '0;
      case (b2[3:0])
         EFF_ARPEGGIO: begin
            if (b3 != 0) begin
               dec.command = CMD_ARPEGGIO;
               dec.data = b3;
            end
         end
         EFF_SLIDE_UP: begin
            dec.command = CMD_SLIDE_UP;
            dec.data = b3;
         end
         EFF_SLIDE_DOWN: begin
            dec.command = CMD_SLIDE_DOWN;
            dec.data = b3;
         end
         EFF_PORTAMENTO: begin
            dec.command = CMD_PORTAMENTO;
            dec.data = b3;
         end
         EFF_OFFSET: begin
            dec.command = CMD_SLICE;
            dec.data = b3;
         end
         EFF_VOL_SLIDE: begin
            if (hi != 0) begin
               dec.command = CMD_CRESC;
               dec.data = 8'(2 * int'(hi));
            end else if (lo != 0) begin
               dec.command = CMD_DECRESC;
               dec.data = 8'(2 * int'(lo));
            end
         end
         EFF_POS_JUMP: begin
            dec.command = CMD_JUMP;
            dec.data = b3;
         end
         EFF_SET_VOL: begin
            dec.command = CMD_VOLUME;
            dec.data = VOLUME_CURVE[(int'(b3) > VOLUME_CEIL) ? VOLUME_CEIL : int'(b3)];
         end
         EFF_PAT_BREAK: begin
            // high nibble read as a decimal digit, even above nine
            dec.command = CMD_BREAK;
            dec.data = 8'(10 * int'(hi) + int'(lo));
         end
         EFF_EXTENDED: begin
            if (hi == EXT_FINE_VOL_UP) begin
               dec.command = CMD_FINE_CRESC;
               dec.data = {4'h0, lo};
            end else if (hi == EXT_FINE_VOL_DOWN) begin
               dec.command = CMD_FINE_DECRESC;
               dec.data = {4'h0, lo};
            end
         end
         EFF_SPEED: begin
            if (b3 != 0 && int'(b3) <= TEMPO_MAX) begin
               dec.command = CMD_TEMPO;
               dec.data = b3;
            end else begin
               // rounded 2*d/5
               dec.command = CMD_TICKS;
               dec.data = 8'((4 * int'(b3) + 5) / 10);
            end
         end
         default: ;
      endcase
      return dec;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      // cap the log; the count still runs
      if (fail_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      decoded_cell_type want;
      if (reset) begin
         expected_cells.delete();
         pending_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_cells.size() == 0) begin
               report_mismatch($sformatf("result transfer with none outstanding (note %0d)",
                                         rsp_note));
            end else begin
               want = expected_cells.pop_front();
               checked_count++;
               if (rsp_note !== want.note)
                  report_mismatch($sformatf("note: got %0d, expected %0d",
                                            rsp_note, want.note));
               if (rsp_instrument !== want.instrument)
                  report_mismatch($sformatf("instrument: got %0d, expected %0d",
                                            rsp_instrument, want.instrument));
               if (rsp_effect_command !== want.command)
                  report_mismatch($sformatf("effect command: got %0d, expected %s",
                                            rsp_effect_command, want.command.name()));
               if (rsp_effect_data !== want.data)
                  report_mismatch($sformatf("effect data: got %0d, expected %0d",
                                            rsp_effect_data, want.data));
            end
         end
         if (start && !busy)
            expected_cells.push_back(decode_cell(req_first_byte, req_second_byte,
                                                 req_third_byte, req_fourth_byte));
         pending_count = expected_cells.size();
      end
   end

endmodule

// ===== sim/mod_pattern_cell_decoder_top_test.sv =====
module mod_pattern_cell_decoder_top_test;
   import mpcd_pkg::*;
   import mpcd_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_CELLS   = 1750;
   localparam int unsigned TAIL_CELLS     = 250;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   localparam logic [7:0] EDGE_PARAMS [8] = '{
      8'h00, 8'h01, 8'h0F, 8'h10, 8'h20, 8'h21, 8'h40, 8'hFF
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_first_byte  = '0;
   logic [7:0] req_second_byte = '0;
   logic [7:0] req_third_byte  = '0;
   logic [7:0] req_fourth_byte = '0;
   logic       rsp_strobe;
   logic [5:0] rsp_note;
   logic [7:0] rsp_instrument;
   logic [3:0] rsp_effect_command;
   logic [7:0] rsp_effect_data;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned cells_sent = 0;
   int unsigned quiet_cycles = 0;

   mod_pattern_cell_decoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_byte     (req_first_byte),
      .req_second_byte    (req_second_byte),
      .req_third_byte     (req_third_byte),
      .req_fourth_byte    (req_fourth_byte),
      .rsp_strobe         (rsp_strobe),
      .rsp_note           (rsp_note),
      .rsp_instrument     (rsp_instrument),
      .rsp_effect_command (rsp_effect_command),
      .rsp_effect_data    (rsp_effect_data)
   );

   mpcd_decode_monitor monitor (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_byte     (req_first_byte),
      .req_second_byte    (req_second_byte),
      .req_third_byte     (req_third_byte),
      .req_fourth_byte    (req_fourth_byte),
      .rsp_strobe         (rsp_strobe),
      .rsp_note           (rsp_note),
      .rsp_instrument     (rsp_instrument),
      .rsp_effect_command (rsp_effect_command),
      .rsp_effect_data    (rsp_effect_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("mod_pattern_cell_decoder_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cell(input logic [11:0] period, input logic [7:0] inst,
                            input logic [3:0] eff, input logic [7:0] param);
      start           <= 1'b1;
      req_first_byte  <= {inst[7:4], period[11:8]};
      req_second_byte <= period[7:0];
      req_third_byte  <= {inst[3:0], eff};
      req_fourth_byte <= param;
      @(negedge clock);
      while (busy) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      cells_sent++;
   endtask

   task automatic idle_for(input int unsigned cycles);
      start           <= 1'b0;
      req_first_byte  <= 8'($urandom);
      req_second_byte <= 8'($urandom);
      req_third_byte  <= 8'($urandom);
      req_fourth_byte <= 8'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [11:0] pick_period();
      int unsigned idx;
      idx = $urandom_range(0, PeriodCount - 2);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 12'($urandom_range(0, 4095));
         2: return 12'($urandom_range(1, PeriodMin - 1));
         3: return 12'($urandom_range(PeriodMax + 1, 4095));
         4, 5: return 12'(PERIOD_TABLE[$urandom_range(0, PeriodCount - 1)]);
         // around the midpoint of neighbouring periods
         6, 7: return 12'((int'(PERIOD_TABLE[idx]) + int'(PERIOD_TABLE[idx + 1])) / 2
                          + $urandom_range(0, 1));
         default: return 12'($urandom_range(PeriodMin, PeriodMax));
      endcase
   endfunction

   function automatic logic [7:0] pick_param(input logic [3:0] eff);
      case ($urandom_range(0, 3))
         0: return EDGE_PARAMS[$urandom_range(0, 7)];
         1: begin
            if (eff == EFF_EXTENDED)
               return {($urandom_range(0, 1) != 0) ? EXT_FINE_VOL_UP : EXT_FINE_VOL_DOWN,
                       4'($urandom)};
            return 8'($urandom_range(0, 8'h41));
         end
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      logic [3:0] eff;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: period edges and ties, every effect, parameter extremes
      send_cell(12'd0,   8'h00, EFF_ARPEGGIO,   8'h00);
      send_cell(12'd856, 8'hFF, EFF_ARPEGGIO,   8'hFF);
      send_cell(12'd113, 8'h5A, EFF_SLIDE_UP,   8'h00);
      send_cell(12'd112, 8'hA5, EFF_SLIDE_DOWN, 8'hFF);
      send_cell(12'd857, 8'h0F, EFF_PORTAMENTO, 8'h80);
      send_cell(12'hFFF, 8'hF0, EFF_VIBRATO,    8'h77);
      send_cell(12'd832, 8'h12, EFF_TONE_VOL,   8'h01);
      send_cell(12'd131, 8'h34, EFF_VIB_VOL,    8'hFF);
      send_cell(12'd116, 8'h56, EFF_TREMOLO,    8'h55);
      send_cell(12'd117, 8'h78, EFF_PAN,        8'hAA);
      send_cell(12'd428, 8'h9A, EFF_OFFSET,     8'hFF);
      send_cell(12'd429, 8'hBC, EFF_VOL_SLIDE,  8'hF0);
      send_cell(12'd300, 8'hDE, EFF_VOL_SLIDE,  8'h0F);
      send_cell(12'd500, 8'h01, EFF_VOL_SLIDE,  8'h00);
      send_cell(12'd640, 8'h10, EFF_POS_JUMP,   8'h7F);
      send_cell(12'd641, 8'h20, EFF_SET_VOL,    8'h40);
      send_cell(12'd200, 8'h30, EFF_SET_VOL,    8'h41);
      send_cell(12'd150, 8'h40, EFF_SET_VOL,    8'h00);
      send_cell(12'd120, 8'h50, EFF_SET_VOL,    8'hFF);
      send_cell(12'd808, 8'h60, EFF_PAT_BREAK,  8'hFF);
      send_cell(12'd762, 8'h70, EFF_EXTENDED,   {EXT_FINE_VOL_UP, 4'h7});
      send_cell(12'd720, 8'h80, EFF_EXTENDED,   {EXT_FINE_VOL_DOWN, 4'hF});
      send_cell(12'd678, 8'h90, EFF_EXTENDED,   8'hC3);
      send_cell(12'd604, 8'hA0, EFF_SPEED,      8'h00);
      send_cell(12'd570, 8'hB0, EFF_SPEED,      8'h01);
      send_cell(12'd538, 8'hC0, EFF_SPEED,      8'h20);
      send_cell(12'd508, 8'hD0, EFF_SPEED,      8'h21);
      send_cell(12'd480, 8'hE0, EFF_SPEED,      8'hFF);

      for (int unsigned i = 0; i < RANDOM_CELLS; i++) begin
         if (i == RANDOM_CELLS / 3 || i == 2 * RANDOM_CELLS / 3)
            wait_for_results();
         else if (i < RANDOM_CELLS - TAIL_CELLS && $urandom_range(0, 5) == 0)
            idle_for($urandom_range(1, 8));
         eff = 4'($urandom);
         send_cell(pick_period(), 8'($urandom), eff, pick_param(eff));
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d cells sent: period edges, ties and out-of-range values, all 16 effects",
               cells_sent);
      $display("%0d decoded results checked, with random start gaps and two full drains",
               checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("mod_pattern_cell_decoder_top: match");
      end else begin
         $display("mod_pattern_cell_decoder_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mpcd_pkg.sv
hw/rtl/mpcd_note.sv
hw/rtl/mpcd_effect.sv
hw/rtl/mod_pattern_cell_decoder_top.sv
sim/mpcd_tb_pkg.sv
sim/mpcd_decode_monitor.sv
sim/mod_pattern_cell_decoder_top_test.sv
